// ===== rtl/qs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the control program of the quicksort sorter.
package qs_pkg;

  localparam int DefaultDepth = 16;
  localparam int KeyW         = 32;
  localparam int StackSlots   = 16;
  localparam int StkIdxW      = $clog2(StackSlots);
  localparam int SpW          = StkIdxW + 1;
  localparam int StepW        = 5;

  // Input and result words.
  typedef struct packed {
    logic signed [KeyW-1:0] key_in;
    logic                   end_of_batch;
  } in_item_t;

  typedef struct packed {
    logic signed [KeyW-1:0] key_out;
    logic                   final_result;
    logic                   keys_dropped;
  } out_item_t;

  // Key memory read address source.
  typedef enum logic [1:0] {
    RD_HI,
    RD_J,
    RD_ST,
    RD_K
  } rd_sel_e;

  // Key memory write source during the sort.
  typedef enum logic [2:0] {
    WR_NONE,
    WR_ST_TA,
    WR_J_TB,
    WR_ST_PIVOT,
    WR_HI_TB
  } wr_sel_e;

  // Range pushed onto the range stack.
  typedef enum logic [1:0] {
    PUSH_FULL,
    PUSH_LEFT,
    PUSH_RIGHT
  } push_sel_e;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_FIRE_LAST,
    C_N_LT2,
    C_SP_ZERO,
    C_NOT_LO_LT_HI,
    C_NOT_J_LT_HI,
    C_NOT_RD_LT_PIVOT,
    C_LEFT_SMALL,
    C_NOT_P_GT_LO1,
    C_NOT_RIGHT_GT1,
    C_P_ZERO,
    C_OUT_BUSY,
    C_K_NOT_LAST
  } cond_e;

  // One control word of the program.
  typedef struct packed {
    logic             accept_in;
    rd_sel_e          rd_sel;
    wr_sel_e          wr_sel;
    logic             ld_pivot;
    logic             ld_ta;
    logic             ld_tb;
    logic             init_part;
    logic             inc_st;
    logic             inc_j;
    logic             set_lo;
    logic             set_hi;
    logic             pop;
    logic             push;
    push_sel_e        push_sel;
    logic             k_clr;
    logic             k_inc;
    logic             emit;
    logic             batch_done;
    cond_e            cond;
    logic [StepW-1:0] target;
  } ctrl_t;

  // Datapath flags that the jump conditions test.
  typedef struct packed {
    logic fire_last;
    logic n_lt2;
    logic sp_zero;
    logic lo_lt_hi;
    logic j_lt_hi;
    logic rd_lt_pivot;
    logic left_small;
    logic p_gt_lo1;
    logic right_gt1;
    logic p_zero;
    logic out_busy;
    logic k_not_last;
  } status_t;

  // Program step addresses.
  localparam logic [StepW-1:0] StLoad   = 5'd0;
  localparam logic [StepW-1:0] StInit   = 5'd1;
  localparam logic [StepW-1:0] StPush0  = 5'd2;
  localparam logic [StepW-1:0] StPopChk = 5'd3;
  localparam logic [StepW-1:0] StPop    = 5'd4;
  localparam logic [StepW-1:0] StWhile  = 5'd5;
  localparam logic [StepW-1:0] StPivot  = 5'd6;
  localparam logic [StepW-1:0] StScan   = 5'd7;
  localparam logic [StepW-1:0] StTest   = 5'd8;
  localparam logic [StepW-1:0] StSwapA  = 5'd9;
  localparam logic [StepW-1:0] StSwapB  = 5'd10;
  localparam logic [StepW-1:0] StNextJ  = 5'd11;
  localparam logic [StepW-1:0] StEndRd  = 5'd12;
  localparam logic [StepW-1:0] StEndA   = 5'd13;
  localparam logic [StepW-1:0] StEndB   = 5'd14;
  localparam logic [StepW-1:0] StRChk   = 5'd15;
  localparam logic [StepW-1:0] StRPush  = 5'd16;
  localparam logic [StepW-1:0] StRNext  = 5'd17;
  localparam logic [StepW-1:0] StLChk   = 5'd18;
  localparam logic [StepW-1:0] StLPush  = 5'd19;
  localparam logic [StepW-1:0] StLZero  = 5'd20;
  localparam logic [StepW-1:0] StLNext  = 5'd21;
  localparam logic [StepW-1:0] StEmRd   = 5'd22;
  localparam logic [StepW-1:0] StEmWait = 5'd23;
  localparam logic [StepW-1:0] StEmit   = 5'd24;
  localparam logic [StepW-1:0] StDone   = 5'd25;

  // Control store: load, Lomuto partition loop, range stack handling, emit.
  function automatic ctrl_t ucode(input logic [StepW-1:0] step);
    ctrl_t c;
    c        = '0;
    c.cond   = C_NEVER;
    c.target = StLoad;
    unique case (step)
      StLoad: begin
        c.accept_in = 1'b1;
        c.cond      = C_NOT_FIRE_LAST;
        c.target    = StLoad;
      end
      StInit: begin
        c.k_clr  = 1'b1;
        c.cond   = C_N_LT2;
        c.target = StEmRd;
      end
      StPush0: begin
        c.push     = 1'b1;
        c.push_sel = PUSH_FULL;
      end
      StPopChk: begin
        c.cond   = C_SP_ZERO;
        c.target = StEmRd;
      end
      StPop: begin
        c.pop = 1'b1;
      end
      StWhile: begin
        c.rd_sel    = RD_HI;
        c.init_part = 1'b1;
        c.cond      = C_NOT_LO_LT_HI;
        c.target    = StPopChk;
      end
      StPivot: begin
        c.ld_pivot = 1'b1;
      end
      StScan: begin
        c.rd_sel = RD_J;
        c.cond   = C_NOT_J_LT_HI;
        c.target = StEndRd;
      end
      StTest: begin
        c.ld_ta  = 1'b1;
        c.rd_sel = RD_ST;
        c.cond   = C_NOT_RD_LT_PIVOT;
        c.target = StNextJ;
      end
      StSwapA: begin
        c.ld_tb  = 1'b1;
        c.wr_sel = WR_ST_TA;
      end
      StSwapB: begin
        c.wr_sel = WR_J_TB;
        c.inc_st = 1'b1;
      end
      StNextJ: begin
        c.inc_j  = 1'b1;
        c.cond   = C_ALWAYS;
        c.target = StScan;
      end
      StEndRd: begin
        c.rd_sel = RD_ST;
      end
      StEndA: begin
        c.ld_tb  = 1'b1;
        c.wr_sel = WR_ST_PIVOT;
      end
      StEndB: begin
        c.wr_sel = WR_HI_TB;
        c.cond   = C_LEFT_SMALL;
        c.target = StLChk;
      end
      StRChk: begin
        c.cond   = C_NOT_P_GT_LO1;
        c.target = StRNext;
      end
      StRPush: begin
        c.push     = 1'b1;
        c.push_sel = PUSH_LEFT;
      end
      StRNext: begin
        c.set_lo = 1'b1;
        c.cond   = C_ALWAYS;
        c.target = StWhile;
      end
      StLChk: begin
        c.cond   = C_NOT_RIGHT_GT1;
        c.target = StLZero;
      end
      StLPush: begin
        c.push     = 1'b1;
        c.push_sel = PUSH_RIGHT;
      end
      StLZero: begin
        c.cond   = C_P_ZERO;
        c.target = StPopChk;
      end
      StLNext: begin
        c.set_hi = 1'b1;
        c.cond   = C_ALWAYS;
        c.target = StWhile;
      end
      StEmRd: begin
        c.rd_sel = RD_K;
      end
      StEmWait: begin
        c.rd_sel = RD_K;
        c.cond   = C_OUT_BUSY;
        c.target = StEmWait;
      end
      StEmit: begin
        c.rd_sel = RD_K;
        c.emit   = 1'b1;
        c.k_inc  = 1'b1;
        c.cond   = C_K_NOT_LAST;
        c.target = StEmRd;
      end
      StDone: begin
        c.batch_done = 1'b1;
        c.cond       = C_ALWAYS;
        c.target     = StLoad;
      end
      default: begin
        c.cond   = C_ALWAYS;
        c.target = StLoad;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/quicksort_sorter_unit.sv =====
`timescale 1ns / 1ps
// Loading accepts one word per cycle. A batch is then sorted in place, its speed set by the key
// memory that carries one read and one write a cycle. Results leave one word at a time: each is
// read, held while the output is stalled, then emitted.
// Reset clears the step counter, key count, drop flag, stack pointer and output valid;
// key memory and range stack hold unknown data until written.
module quicksort_sorter_unit import qs_pkg::*; #(
  parameter int DEPTH = DefaultDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  ctrl_t   ctrl;
  status_t status;

  // Microcoded control.
  qs_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // Storage and arithmetic.
  qs_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  // Checks that a new word goes only into an empty output register.
  a_emit_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |-> !out_valid_o) else $error("emit into full output register");

  // The range stack is never popped when empty.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop |-> !status.sp_zero) else $error("pop from empty range stack");

  // Every pushed range has been consumed by the end of a batch.
  a_stack_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.batch_done |-> status.sp_zero) else $error("range stack not empty at batch end");
`endif

endmodule

// ===== rtl/qs_sequencer.sv =====
`timescale 1ns / 1ps
// Step counter, control store and jump logic of the quicksort sorter.
module qs_sequencer import qs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  logic [StepW-1:0] upc_q, upc_d;
  logic             take;

  // Control word of the current step.
  always_comb ctrl_o = ucode(upc_q);

  // Jump condition select.
  always_comb begin
    unique case (ctrl_o.cond)
      C_NEVER:           take = 1'b0;
      C_ALWAYS:          take = 1'b1;
      C_NOT_FIRE_LAST:   take = !status_i.fire_last;
      C_N_LT2:           take = status_i.n_lt2;
      C_SP_ZERO:         take = status_i.sp_zero;
      C_NOT_LO_LT_HI:    take = !status_i.lo_lt_hi;
      C_NOT_J_LT_HI:     take = !status_i.j_lt_hi;
      C_NOT_RD_LT_PIVOT: take = !status_i.rd_lt_pivot;
      C_LEFT_SMALL:      take = status_i.left_small;
      C_NOT_P_GT_LO1:    take = !status_i.p_gt_lo1;
      C_NOT_RIGHT_GT1:   take = !status_i.right_gt1;
      C_P_ZERO:          take = status_i.p_zero;
      C_OUT_BUSY:        take = status_i.out_busy;
      C_K_NOT_LAST:      take = status_i.k_not_last;
      default:           take = 1'b1;
    endcase
  end

  assign upc_d = take ? ctrl_o.target : upc_q + 1'b1;

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= StLoad;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ===== rtl/qs_datapath.sv =====
`timescale 1ns / 1ps
// Key memory, range stack, index registers and output register of the sorter.
module qs_datapath import qs_pkg::*; #(
  parameter int DEPTH = DefaultDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_t     ctrl_i,
  output status_t   status_o,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = 2 * IW;

  // Key memory and its registered read.
  logic signed [KeyW-1:0] key_mem [DEPTH];
  logic signed [KeyW-1:0] rd_q;
  logic [IW-1:0]          mem_ra, mem_wa;
  logic signed [KeyW-1:0] mem_wd;
  logic                   mem_we;

  // Range stack and its registered read of the top entry.
  logic [EW-1:0]      stack_mem [StackSlots];
  logic [EW-1:0]      stk_rd_q;
  logic [EW-1:0]      stk_wd;
  logic               stk_we;
  logic [SpW-1:0]     sp_q, sp_d;
  logic [SpW-1:0]     sp_top;

  // Control state.
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          out_valid_q, out_valid_d;

  // Working registers.
  logic [CW-1:0]          lo_q, lo_d, hi_q, hi_d, j_q, j_d, st_q, st_d, k_q, k_d;
  logic signed [KeyW-1:0] pivot_q, pivot_d, ta_q, ta_d, tb_q, tb_d;
  out_item_t              out_item_q, out_item_d;

  logic          in_fire;
  logic [CW-1:0] n_last, left_len, right_len, push_lo, push_hi;

  assign in_stall_o = !ctrl_i.accept_in;
  assign in_fire    = in_valid_i && ctrl_i.accept_in;
  assign n_last     = count_q - 1'b1;
  assign left_len   = st_q - lo_q;
  assign right_len  = hi_q - st_q;
  assign sp_top     = sp_q - 1'b1;

  // Flags for the jump logic.
  always_comb begin
    status_o.fire_last   = in_fire && in_item_i.end_of_batch;
    status_o.n_lt2       = count_q < CW'(2);
    status_o.sp_zero     = sp_q == '0;
    status_o.lo_lt_hi    = lo_q < hi_q;
    status_o.j_lt_hi     = j_q < hi_q;
    status_o.rd_lt_pivot = rd_q < pivot_q;
    status_o.left_small  = left_len < right_len;
    status_o.p_gt_lo1    = {1'b0, st_q} > ({1'b0, lo_q} + 1'b1);
    status_o.right_gt1   = right_len > CW'(1);
    status_o.p_zero      = st_q == '0;
    status_o.out_busy    = out_valid_q && out_stall_i;
    status_o.k_not_last  = k_q != n_last;
  end

  // Key memory read address.
  always_comb begin
    case (ctrl_i.rd_sel)
      RD_HI:   mem_ra = hi_q[IW-1:0];
      RD_J:    mem_ra = j_q[IW-1:0];
      RD_ST:   mem_ra = st_q[IW-1:0];
      default: mem_ra = k_q[IW-1:0];
    endcase
  end

  // Key memory write port: loading a word or one half of an exchange.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = count_q[IW-1:0];
    mem_wd = in_item_i.key_in;
    case (ctrl_i.wr_sel)
      WR_NONE: begin
        mem_we = in_fire && (count_q < CW'(DEPTH));
      end
      WR_ST_TA: begin
        mem_we = 1'b1;
        mem_wa = st_q[IW-1:0];
        mem_wd = ta_q;
      end
      WR_J_TB: begin
        mem_we = 1'b1;
        mem_wa = j_q[IW-1:0];
        mem_wd = tb_q;
      end
      WR_ST_PIVOT: begin
        mem_we = 1'b1;
        mem_wa = st_q[IW-1:0];
        mem_wd = pivot_q;
      end
      WR_HI_TB: begin
        mem_we = 1'b1;
        mem_wa = hi_q[IW-1:0];
        mem_wd = tb_q;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[mem_wa] <= mem_wd;
    end
    rd_q <= key_mem[mem_ra];
  end

  // Range to push.
  always_comb begin
    case (ctrl_i.push_sel)
      PUSH_FULL: begin
        push_lo = '0;
        push_hi = n_last;
      end
      PUSH_LEFT: begin
        push_lo = lo_q;
        push_hi = st_q - 1'b1;
      end
      default: begin
        push_lo = st_q + 1'b1;
        push_hi = hi_q;
      end
    endcase
  end

  assign stk_wd = {push_lo[IW-1:0], push_hi[IW-1:0]};
  assign stk_we = ctrl_i.push && (sp_q < SpW'(StackSlots));

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[sp_q[StkIdxW-1:0]] <= stk_wd;
    end
    stk_rd_q <= stack_mem[sp_top[StkIdxW-1:0]];
  end

  // Next values of the working and control registers.
  always_comb begin
    lo_d        = lo_q;
    hi_d        = hi_q;
    j_d         = j_q;
    st_d        = st_q;
    k_d         = k_q;
    pivot_d     = pivot_q;
    ta_d        = ta_q;
    tb_d        = tb_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    sp_d        = sp_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (in_fire) begin
      if (count_q < CW'(DEPTH)) begin
        count_d = count_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (ctrl_i.init_part) begin
      st_d = lo_q;
      j_d  = lo_q;
    end
    if (ctrl_i.inc_st) st_d = st_q + 1'b1;
    if (ctrl_i.inc_j) j_d = j_q + 1'b1;
    if (ctrl_i.set_lo) lo_d = st_q + 1'b1;
    if (ctrl_i.set_hi) hi_d = st_q - 1'b1;
    if (ctrl_i.pop) begin
      lo_d = CW'(stk_rd_q[EW-1:IW]);
      hi_d = CW'(stk_rd_q[IW-1:0]);
      sp_d = sp_top;
    end
    if (stk_we) sp_d = sp_q + 1'b1;
    if (ctrl_i.ld_pivot) pivot_d = rd_q;
    if (ctrl_i.ld_ta) ta_d = rd_q;
    if (ctrl_i.ld_tb) tb_d = rd_q;
    if (ctrl_i.k_clr) k_d = '0;
    if (ctrl_i.k_inc) k_d = k_q + 1'b1;
    if (ctrl_i.emit) begin
      out_valid_d             = 1'b1;
      out_item_d.key_out      = rd_q;
      out_item_d.final_result = k_q == n_last;
      out_item_d.keys_dropped = ovf_q;
    end
    if (ctrl_i.batch_done) begin
      count_d = '0;
      ovf_d   = 1'b0;
      sp_d    = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    j_q        <= j_d;
    st_q       <= st_d;
    k_q        <= k_d;
    pivot_q    <= pivot_d;
    ta_q       <= ta_d;
    tb_q       <= tb_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the quicksort sorter: batches of keys in, sorted words out.
module testbench;
  import qs_pkg::*;

  localparam int BatchDepth = DefaultDepth;

  // Key patterns used to fill a random batch.
  typedef enum int {
    KEYS_SPREAD,
    KEYS_CLUSTERED,
    KEYS_EXTREME,
    KEYS_RISING,
    KEYS_FALLING
  } key_mix_e;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  quicksort_sorter_unit #(.DEPTH(BatchDepth)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hold reset low at the start, then release it.
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  in_item_t  pending_words[$];
  out_item_t sorted_words[$];
  out_item_t next_want;
  int        total_words    = 1;
  int        words_taken    = 0;
  int        mismatch_count = 0;
  int        idle_phase     = 0;
  int        send_idle_pct[3] = '{28, 87, 0};
  int        recv_idle_pct[3] = '{87, 28, 0};

  // Shadow of the batch being loaded.
  logic signed [KeyW-1:0] batch_keys[BatchDepth];
  int                     batch_fill     = 0;
  logic                   batch_overflow = 1'b0;

  // Store one accepted word; on the last word of a batch, sort the stored keys and
  // queue one expected result per stored key.
  function automatic void absorb_key(input in_item_t w);
    logic signed [KeyW-1:0] run[BatchDepth];
    logic signed [KeyW-1:0] hold;
    out_item_t              r;
    int                     j;
    if (batch_fill < BatchDepth) begin
      batch_keys[batch_fill] = w.key_in;
      batch_fill++;
    end else begin
      batch_overflow = 1'b1;
    end
    if (w.end_of_batch) begin
      for (int i = 0; i < batch_fill; i++) run[i] = batch_keys[i];
      for (int i = 1; i < batch_fill; i++) begin
        hold = run[i];
        j = i - 1;
        while (j >= 0 && run[j] > hold) begin
          run[j + 1] = run[j];
          j--;
        end
        run[j + 1] = hold;
      end
      for (int k = 0; k < batch_fill; k++) begin
        r.key_out      = run[k];
        r.final_result = (k == batch_fill - 1);
        r.keys_dropped = batch_overflow;
        sorted_words.push_back(r);
      end
      batch_fill     = 0;
      batch_overflow = 1'b0;
    end
  endfunction

  function automatic void queue_key(input logic [KeyW-1:0] key, input logic last);
    in_item_t w;
    w.key_in       = key;
    w.end_of_batch = last;
    pending_words.push_back(w);
  endfunction

  // One batch of the given length with keys drawn from the given pattern.
  function automatic void queue_batch(input int count, input key_mix_e mix);
    logic [KeyW-1:0] extremes[5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1};
    logic [KeyW-1:0] base;
    logic [KeyW-1:0] key;
    base = $urandom_range(1 << 20, 0) - (1 << 19);
    for (int i = 0; i < count; i++) begin
      case (mix)
        KEYS_SPREAD:    key = $urandom;
        KEYS_CLUSTERED: key = $urandom_range(4, 0) - 2;
        KEYS_EXTREME:   key = extremes[$urandom_range(4, 0)];
        KEYS_RISING:    key = base + i * $urandom_range(3, 0);
        default:        key = base - i * $urandom_range(3, 0);
      endcase
      queue_key(key, i == count - 1);
    end
  endfunction

  // Driver: hold a stalled word, otherwise offer the next pending word or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        absorb_key(in_item_i);
        words_taken++;
        idle_phase <= (words_taken * 3 >= total_words * 2) ? 2 :
                      (words_taken * 3 >= total_words) ? 1 : 0;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_words.size() > 0 &&
            $urandom_range(99, 0) >= send_idle_pct[idle_phase]) begin
          in_valid_i <= 1'b1;
          in_item_i  <= pending_words.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result word with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (sorted_words.size() == 0) begin
          $error("result word with nothing expected: key_out %0d", out_item_o.key_out);
          mismatch_count++;
        end else begin
          next_want = sorted_words.pop_front();
          if (out_item_o.key_out !== next_want.key_out) begin
            $error("key_out: expected %0d, got %0d", next_want.key_out, out_item_o.key_out);
            mismatch_count++;
          end
          if (out_item_o.final_result !== next_want.final_result) begin
            $error("final_result: expected %0b, got %0b",
                   next_want.final_result, out_item_o.final_result);
            mismatch_count++;
          end
          if (out_item_o.keys_dropped !== next_want.keys_dropped) begin
            $error("keys_dropped: expected %0b, got %0b",
                   next_want.keys_dropped, out_item_o.keys_dropped);
            mismatch_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99, 0) < recv_idle_pct[idle_phase]);
    end
  end

  // Stimulus and end of run.
  initial begin
    int       random_words;
    int       count;
    key_mix_e mix;
    // A batch of one key, which needs no sorting.
    queue_key(32'h7FFF_FFFF, 1'b1);
    // The extremes of the key range in mixed order.
    queue_key(32'h0, 1'b0);
    queue_key(32'h8000_0000, 1'b0);
    queue_key(32'hFFFF_FFFF, 1'b0);
    queue_key(32'h0000_0001, 1'b0);
    queue_key(32'h7FFF_FFFF, 1'b1);
    // Overlong batch: the last two keys are dropped, the flagged one among them.
    for (int i = 0; i < BatchDepth + 2; i++) begin
      queue_key((i % 3 == 0) ? 32'h0001_0000 : 32'hFFFF_0000 - i, i == BatchDepth + 1);
    end

    // Random batches, mostly within the depth, some too long.
    random_words = 0;
    while (random_words < 176) begin
      if ($urandom_range(99, 0) < 12) begin
        count = BatchDepth + $urandom_range(5, 1);
      end else begin
        count = $urandom_range(BatchDepth, 1);
      end
      mix = key_mix_e'($urandom_range(4, 0));
      queue_batch(count, mix);
      random_words += count;
    end
    total_words = pending_words.size();

    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    while (pending_words.size() != 0 || in_valid_i) @(posedge clk_i);
    while (sorted_words.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== quicksort_sorter_unit.f =====
rtl/qs_pkg.sv
rtl/qs_sequencer.sv
rtl/qs_datapath.sv
rtl/quicksort_sorter_unit.sv
verif/testbench.sv
